// ===== design/keyed_sorted_entry_table_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the keyed sorted entry table unit.
// Defining ASSERT_OFF turns every macro into an empty body.
// ---------------------------------------------------------------------------
`ifndef KEYED_SORTED_ENTRY_TABLE_UNIT_ASSERT_SVH
`define KEYED_SORTED_ENTRY_TABLE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define KSETU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// An implication: when ante holds, cons must hold at the same edge.
`define KSETU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define KSETU_ASSERT(lbl, clk, rst, prop, msg)
`define KSETU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== design/ksetu_pkg.sv =====
// ---------------------------------------------------------------------------
// ksetu_pkg
// Types and constants shared by the keyed sorted entry table modules.
// ---------------------------------------------------------------------------
package ksetu_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam logic [2:0] KIND_ADD      = 3'd0;
   localparam logic [2:0] KIND_DEL_KEY  = 3'd1;
   localparam logic [2:0] KIND_DEL_HEAD = 3'd2;
   localparam logic [2:0] KIND_RESCHED  = 3'd3;
   localparam logic [2:0] KIND_LOOKUP   = 3'd4;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic [4:0] LIMIT_RESET = 5'd16;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [31:0] sort_key;
      logic [31:0] data_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_data;
      logic        head_valid;
      logic [31:0] head_sort_key;
      logic [31:0] head_data;
      logic [4:0]  entry_count;
      logic        is_full;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [31:0] sort_key;
      logic [31:0] data_handle;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_INS,
      ST_HEAD,
      ST_HEADW
   } state_type;

   typedef enum logic [1:0] {
      LIST_HOLD,
      LIST_REMOVE,
      LIST_INSERT
   } list_op_type;

endpackage

// ===== design/ksetu_mem.sv =====
// ---------------------------------------------------------------------------
// ksetu_mem
// Entry memory, one entry per slot, one write and one registered read port.
// ---------------------------------------------------------------------------
module ksetu_mem #(
   parameter int CAPACITY = ksetu_pkg::CAPACITY_DEF,
   parameter int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [SW-1:0]        wr_addr,
   input  ksetu_pkg::entry_type wr_data,
   input  logic                 rd_en,
   input  logic [SW-1:0]        rd_addr,
   output ksetu_pkg::entry_type rd_data
);
   import ksetu_pkg::*;

   entry_type mem_ff [CAPACITY];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ksetu_list.sv =====
// ---------------------------------------------------------------------------
// ksetu_list
// Ordered list of slot numbers with remove-by-slot and insert-at-position.
// ---------------------------------------------------------------------------
module ksetu_list #(
   parameter int CAPACITY = ksetu_pkg::CAPACITY_DEF,
   parameter int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   parameter int CW = $clog2(CAPACITY + 1)
) (
   input  logic                   clock,
   input  ksetu_pkg::list_op_type op,
   input  logic [SW-1:0]          slot,
   input  logic [CW-1:0]          pos,
   input  logic [CW-1:0]          n,
   input  logic [SW-1:0]          rd_idx,
   output logic [SW-1:0]          rd_slot,
   output logic [SW-1:0]          head_slot
);
   import ksetu_pkg::*;

   logic [SW-1:0] list_ff [CAPACITY];
   logic [SW-1:0] list_in [CAPACITY];
   logic [CW-1:0] rm_pos;

   // The removed slot sits at the lowest matching place among the first n.
   always_comb begin
      rm_pos = n;
      for (int k = CAPACITY - 1; k >= 0; k--) begin
         if (CW'(k) < n && list_ff[k] == slot) begin
            rm_pos = CW'(k);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < CAPACITY; k++) begin
         list_in[k] = list_ff[k];
         case (op)
            LIST_REMOVE: begin
               if (CW'(k) >= rm_pos && k < CAPACITY - 1) begin
                  list_in[k] = list_ff[(k < CAPACITY - 1) ? k + 1 : k];
               end
            end
            LIST_INSERT: begin
               if (CW'(k) == pos) begin
                  list_in[k] = slot;
               end else if (CW'(k) > pos) begin
                  list_in[k] = list_ff[(k > 0) ? k - 1 : 0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      list_ff <= list_in;
   end

   assign rd_slot   = list_ff[rd_idx];
   assign head_slot = list_ff[0];

endmodule

// ===== design/keyed_sorted_entry_table_unit.sv =====
// ---------------------------------------------------------------------------
// keyed_sorted_entry_table_unit
// Bounded table of keyed entries kept in ascending sort-key order.
// ---------------------------------------------------------------------------
//
//   channel  ports                         direction  carries
//   req      req_valid/req_ready/req_item  in         one operation item
//   rsp      rsp_valid/rsp_ready/rsp_item  out        one result item
//   csr      csr_valid/csr_ready/csr_data  in         entry_limit write
//
// One item is handled at a time. An item is accepted, then a key scan runs
// for delete by key, reschedule and lookup, a sort scan over the entries
// ahead of the scan runs for add and reschedule, and last the head entry is
// fetched. All scans go through the single read port of the entry memory,
// one entry per cycle, and the last compare lands in the cycle after its
// read. After synchronous reset the table is empty and the limit is 16. The
// result sits in an output register, so a stalled rsp side only holds the
// next item at its head fetch.
//
`include "keyed_sorted_entry_table_unit_assert.svh"

module keyed_sorted_entry_table_unit #(
   parameter int CAPACITY = ksetu_pkg::CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ksetu_pkg::req_type req_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ksetu_pkg::rsp_type rsp_item,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [4:0]         csr_data
);
   import ksetu_pkg::*;

   localparam int SW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CW > 5) ? CW : 5;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [1:0]       status_ff, status_in;
   logic [31:0]      found_ff, found_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [4:0]       limit_ff, limit_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    m_ff, m_in;
   logic             pend_ff, pend_in;
   logic [CW-1:0]    cmp_pos_ff, cmp_pos_in;
   logic [SW-1:0]    rd_slot_ff, rd_slot_in;
   logic             hit_ff, hit_in;
   logic [SW-1:0]    hit_slot_ff, hit_slot_in;
   entry_type        hit_ent_ff, hit_ent_in;
   logic             pos_ok_ff, pos_ok_in;
   logic [CW-1:0]    ins_pos_ff, ins_pos_in;
   logic [SW-1:0]    slot_ff, slot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   list_op_type      ord_op, add_op;
   logic [SW-1:0]    ord_slot, add_slot, ord_rd_slot, add_rd_slot, ord_head, add_head;
   logic [CW-1:0]    ord_pos, add_pos, ord_n, find_idx, ins_at;
   logic             mem_we, mem_re;
   logic [SW-1:0]    mem_waddr, mem_raddr;
   entry_type        mem_wdata, mem_q;
   logic [SW-1:0]    free_slot;
   logic [CMP_W-1:0] eff_limit;
   logic             at_limit;

   // Limit clipped to the table size; full once the count reaches it.
   assign eff_limit = (CMP_W'(limit_ff) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY)
                                                          : CMP_W'(limit_ff);
   assign at_limit  = CMP_W'(count_ff) >= eff_limit;

   // Lowest free slot.
   always_comb begin
      free_slot = '0;
      for (int k = CAPACITY - 1; k >= 0; k--) begin
         if (!valid_ff[k]) begin
            free_slot = SW'(k);
         end
      end
   end

   // The key scan walks the add order from newest to oldest.
   assign find_idx = count_ff - cnt_ff - CW'(1);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      count_in     = count_ff;
      valid_in     = valid_ff;
      limit_in     = limit_ff;
      cnt_in       = cnt_ff;
      m_in         = m_ff;
      pend_in      = 1'b0;
      cmp_pos_in   = cmp_pos_ff;
      rd_slot_in   = rd_slot_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      hit_ent_in   = hit_ent_ff;
      pos_ok_in    = pos_ok_ff;
      ins_pos_in   = ins_pos_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ord_op       = LIST_HOLD;
      add_op       = LIST_HOLD;
      ord_slot     = slot_ff;
      add_slot     = slot_ff;
      ord_pos      = ins_pos_ff;
      add_pos      = count_ff;
      ord_n        = count_ff;
      ins_at       = pos_ok_ff ? ins_pos_ff : m_ff;
      mem_we       = 1'b0;
      mem_waddr    = slot_ff;
      mem_wdata    = '{req_ff.key_high, req_ff.key_low, req_ff.sort_key,
                       req_ff.data_handle};
      mem_re       = 1'b0;
      mem_raddr    = ord_head;

      if (csr_valid) begin
         limit_in = csr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_item;
               status_in = STATUS_DONE;
               found_in  = '0;
               cnt_in    = '0;
               hit_in    = 1'b0;
               pos_ok_in = 1'b0;
               m_in      = count_ff;
               case (req_item.kind)
                  KIND_ADD: begin
                     if (at_limit) begin
                        status_in = STATUS_FULL;
                        state_in  = ST_HEAD;
                     end else begin
                        slot_in  = free_slot;
                        state_in = ST_INS;
                     end
                  end
                  KIND_DEL_KEY, KIND_RESCHED, KIND_LOOKUP: begin
                     state_in = ST_FIND;
                  end
                  KIND_DEL_HEAD: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_MISS;
                     end else begin
                        ord_op   = LIST_REMOVE;
                        add_op   = LIST_REMOVE;
                        ord_slot = ord_head;
                        add_slot = ord_head;
                        valid_in[ord_head] = 1'b0;
                        count_in = count_ff - CW'(1);
                     end
                     state_in = ST_HEAD;
                  end
                  default: begin
                     status_in = STATUS_MISS;
                     state_in  = ST_HEAD;
                  end
               endcase
            end
         end
         ST_FIND: begin
            if (cnt_ff < m_ff) begin
               mem_re     = 1'b1;
               mem_raddr  = add_rd_slot;
               pend_in    = 1'b1;
               rd_slot_in = add_rd_slot;
               cnt_in     = cnt_ff + CW'(1);
            end
            if (pend_ff && !hit_ff && mem_q.key_high == req_ff.key_high &&
                mem_q.key_low == req_ff.key_low) begin
               hit_in      = 1'b1;
               hit_slot_in = rd_slot_ff;
               hit_ent_in  = mem_q;
            end
            if (cnt_ff == m_ff && !pend_ff) begin
               state_in = ST_HEAD;
               if (!hit_ff) begin
                  status_in = STATUS_MISS;
               end else begin
                  case (req_ff.kind)
                     KIND_DEL_KEY: begin
                        ord_op   = LIST_REMOVE;
                        add_op   = LIST_REMOVE;
                        ord_slot = hit_slot_ff;
                        add_slot = hit_slot_ff;
                        valid_in[hit_slot_ff] = 1'b0;
                        count_in = count_ff - CW'(1);
                     end
                     KIND_LOOKUP: begin
                        found_in = hit_ent_ff.data_handle;
                     end
                     KIND_RESCHED: begin
                        // Take the entry out of the order, then place it anew.
                        ord_op    = LIST_REMOVE;
                        ord_slot  = hit_slot_ff;
                        slot_in   = hit_slot_ff;
                        m_in      = count_ff - CW'(1);
                        cnt_in    = '0;
                        pos_ok_in = 1'b0;
                        state_in  = ST_INS;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_INS: begin
            if (cnt_ff < m_ff) begin
               mem_re     = 1'b1;
               mem_raddr  = ord_rd_slot;
               pend_in    = 1'b1;
               cmp_pos_in = cnt_ff;
               cnt_in     = cnt_ff + CW'(1);
            end
            // First entry with an equal or greater sort key marks the place.
            if (pend_ff && !pos_ok_ff && mem_q.sort_key >= req_ff.sort_key) begin
               pos_ok_in  = 1'b1;
               ins_pos_in = cmp_pos_ff;
            end
            if (cnt_ff == m_ff && !pend_ff) begin
               ord_op   = LIST_INSERT;
               ord_pos  = ins_at;
               mem_we   = 1'b1;
               state_in = ST_HEAD;
               if (req_ff.kind == KIND_ADD) begin
                  add_op   = LIST_INSERT;
                  add_pos  = count_ff;
                  valid_in[slot_ff] = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  mem_wdata = '{hit_ent_ff.key_high, hit_ent_ff.key_low,
                                req_ff.sort_key, hit_ent_ff.data_handle};
               end
            end
         end
         ST_HEAD: begin
            mem_re    = count_ff != '0;
            mem_raddr = ord_head;
            state_in  = ST_HEADW;
         end
         ST_HEADW: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = status_ff;
               rsp_in.found_data    = found_ff;
               rsp_in.head_valid    = count_ff != '0;
               rsp_in.head_sort_key = (count_ff != '0) ? mem_q.sort_key : '0;
               rsp_in.head_data     = (count_ff != '0) ? mem_q.data_handle : '0;
               rsp_in.entry_count   = 5'(count_ff);
               rsp_in.is_full       = at_limit;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         valid_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         pos_ok_ff    <= 1'b0;
         cnt_ff       <= '0;
         m_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         limit_ff     <= limit_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         pos_ok_ff    <= pos_ok_in;
         cnt_ff       <= cnt_in;
         m_ff         <= m_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      cmp_pos_ff  <= cmp_pos_in;
      rd_slot_ff  <= rd_slot_in;
      hit_slot_ff <= hit_slot_in;
      hit_ent_ff  <= hit_ent_in;
      ins_pos_ff  <= ins_pos_in;
      slot_ff     <= slot_in;
      rsp_ff      <= rsp_in;
   end

   ksetu_mem #(.CAPACITY(CAPACITY)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_q)
   );

   // Sort order of the held slots.
   ksetu_list #(.CAPACITY(CAPACITY)) u_order (
      .clock     (clock),
      .op        (ord_op),
      .slot      (ord_slot),
      .pos       (ord_pos),
      .n         (ord_n),
      .rd_idx    (cnt_ff[SW-1:0]),
      .rd_slot   (ord_rd_slot),
      .head_slot (ord_head)
   );

   // Add order of the held slots; the newest key match wins.
   ksetu_list #(.CAPACITY(CAPACITY)) u_age (
      .clock     (clock),
      .op        (add_op),
      .slot      (add_slot),
      .pos       (add_pos),
      .n         (count_ff),
      .rd_idx    (find_idx[SW-1:0]),
      .rd_slot   (add_rd_slot),
      .head_slot (add_head)
   );

   assign req_ready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `KSETU_ASSERT(a_count_cap, clock, reset, count_ff <= CW'(CAPACITY), "count above capacity")
   `KSETU_ASSERT(a_valid_count, clock, reset, $countones(valid_ff) == count_ff, "valid bits disagree with count")
   `KSETU_ASSERT_IMP(a_rsp_from_head, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_HEADW), "result raised outside head fetch")
   `KSETU_ASSERT_IMP(a_age_head, clock, reset, count_ff == CW'(1) && state_ff == ST_IDLE, add_head == ord_head, "single entry lists disagree")

endmodule
